/* rtl/core/lla_pkg.sv */
// Shared constants, codes and types of the least-loaded core affinity block.
// No dependencies; every other file in rtl/core but lla_table refers to it by scoped names.

package lla_pkg;

  localparam int TABLE_DEPTH_DEF = 65536;
  localparam int CORE_COUNT_DEF  = 4;
  localparam int REF_BITS_DEF    = 16;

  localparam int FILE_BITS       = 16;
  localparam int CORE_FIELD_BITS = 2;
  localparam int LOAD_BITS       = 32;

  localparam logic OP_OPEN  = 1'b0;
  localparam logic OP_CLOSE = 1'b1;

  typedef enum logic [1:0] {
    ST_OPENED    = 2'd0,
    ST_CLOSED    = 2'd1,
    ST_REDUNDANT = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic inc;
    logic dec;
  } load_op_t;

endpackage

/* rtl/core/lla_index.sv */
// File number register and reduction of the file number to a table address.
// Depends on lla_pkg for the file number width.

module lla_index #(
  parameter int TABLE_DEPTH = lla_pkg::TABLE_DEPTH_DEF,
  localparam int ADDR_BITS  = $clog2(TABLE_DEPTH)
) (
  input  logic                           clk,
  input  logic                           capture,
  input  logic [lla_pkg::FILE_BITS-1:0]  file_number,
  output logic [ADDR_BITS-1:0]           idx
);

  localparam int  FB       = lla_pkg::FILE_BITS;
  localparam bit  WIDE     = TABLE_DEPTH >= (1 << FB);
  localparam bit  POW2     = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;

  logic [FB-1:0] fn_q;

  always_ff @(posedge clk) begin
    if (capture) begin
      fn_q <= file_number;
    end
  end

  generate
    if (WIDE) begin : g_wide
      assign idx = ADDR_BITS'(fn_q);
    end else if (POW2) begin : g_pow2
      assign idx = fn_q[ADDR_BITS-1:0];
    end else begin : g_recip
      localparam logic [32:0] RECIP =
        33'(((64'd1 << 32) + 64'(TABLE_DEPTH) - 64'd1) / 64'(TABLE_DEPTH));
      localparam logic [FB-1:0] DEPTH_C = FB'(TABLE_DEPTH);
      logic [FB+32:0]   prod;
      logic [FB-1:0]    quot;
      logic [2*FB-1:0]  back;
      logic [FB-1:0]    rem;

      always_ff @(posedge clk) begin
        if (capture) begin
          prod <= (FB+33)'(file_number) * (FB+33)'(RECIP);
        end
      end

      assign quot = prod[FB+31:32];
      assign back = (2*FB)'(quot) * (2*FB)'(DEPTH_C);
      assign rem  = fn_q - back[FB-1:0];
      assign idx  = rem[ADDR_BITS-1:0];
    end
  endgenerate

endmodule

/* rtl/core/lla_table.sv */
// Open-file table: one synchronous memory with one write and one read port.
// Sweeps every entry to zero after reset. No package dependencies.

module lla_table #(
  parameter int TABLE_DEPTH = 65536,
  parameter int WIDTH       = 18,
  localparam int ADDR_BITS  = $clog2(TABLE_DEPTH)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [WIDTH-1:0]     rd_data,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [WIDTH-1:0]     wr_data,
  output logic                 ready
);

  logic [WIDTH-1:0]     mem [0:TABLE_DEPTH-1];
  logic                 clearing;
  logic [ADDR_BITS-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == ADDR_BITS'(TABLE_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + ADDR_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign ready = !clearing;

endmodule

/* rtl/core/lla_load.sv */
// Per-core usage counters and the registered least-loaded core choice.
// Depends on lla_pkg for the counter width and the update word type.

module lla_load #(
  parameter int CORE_COUNT = lla_pkg::CORE_COUNT_DEF,
  localparam int CORE_BITS = $clog2(CORE_COUNT)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lla_pkg::load_op_t     op,
  input  logic [CORE_BITS-1:0]  sel,
  output logic                  sel_full,
  output logic [CORE_BITS-1:0]  best
);

  localparam int LB  = lla_pkg::LOAD_BITS;
  localparam int PAD = 1 << CORE_BITS;

  logic [LB-1:0]        load [0:CORE_COUNT-1];
  logic [LB-1:0]        tv   [0:CORE_BITS][0:PAD-1];
  logic [CORE_BITS-1:0] ti   [0:CORE_BITS][0:PAD-1];

  always_comb begin
    for (int l = 0; l <= CORE_BITS; l++) begin
      for (int j = 0; j < PAD; j++) begin
        tv[l][j] = '1;
        ti[l][j] = CORE_BITS'(j);
      end
    end
    for (int j = 0; j < CORE_COUNT; j++) begin
      tv[0][j] = load[j];
    end
    for (int l = 1; l <= CORE_BITS; l++) begin
      for (int j = 0; j < (PAD >> l); j++) begin
        if (tv[l-1][2*j+1] < tv[l-1][2*j]) begin
          tv[l][j] = tv[l-1][2*j+1];
          ti[l][j] = ti[l-1][2*j+1];
        end else begin
          tv[l][j] = tv[l-1][2*j];
          ti[l][j] = ti[l-1][2*j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CORE_COUNT; i++) begin
        load[i] <= '0;
      end
      best <= '0;
    end else begin
      if (op.inc) begin
        load[sel] <= load[sel] + LB'(1);
      end else if (op.dec && load[sel] != '0) begin
        load[sel] <= load[sel] - LB'(1);
      end
      best <= ti[CORE_BITS][0];
    end
  end

  assign sel_full = load[sel] == '1;

endmodule

/* rtl/core/least_loaded_core_affinity_top.sv */
// Top level of the least-loaded core affinity block: sequencer, result register.
// Depends on lla_pkg, lla_index, lla_table and lla_load.
//
// After reset, busy stays high while the file table is swept to zero. From
// then on each word passes through the accept in S_IDLE, S_ADDR to form the
// table address and read the entry, and S_EXEC to update the entry and the
// core counters; busy is high for the latter two, and start is taken again in
// the cycle right after. The sequence is set by the registered table address
// and the registered read of the file table ahead of the update. The result
// appears with done for exactly one cycle, registered as S_EXEC ends, and is
// lost if not taken then: the receiver cannot stall the block.

module least_loaded_core_affinity_top #(
  parameter int TABLE_DEPTH = lla_pkg::TABLE_DEPTH_DEF,
  parameter int CORE_COUNT  = lla_pkg::CORE_COUNT_DEF,
  parameter int REF_BITS    = lla_pkg::REF_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 operation,
  input  logic [lla_pkg::FILE_BITS-1:0]        file_number,
  output logic                                 done,
  output logic [lla_pkg::CORE_FIELD_BITS-1:0]  core,
  output logic [1:0]                           status
);

  localparam int ADDR_BITS = $clog2(TABLE_DEPTH);
  localparam int CORE_BITS = $clog2(CORE_COUNT);
  localparam int WIDTH     = REF_BITS + CORE_BITS;
  localparam int CFB       = lla_pkg::CORE_FIELD_BITS;

  typedef enum logic [1:0] {S_IDLE, S_ADDR, S_EXEC} state_t;

  state_t                   state;
  logic                     accept;
  logic                     op_q;
  logic [ADDR_BITS-1:0]     idx;
  logic [WIDTH-1:0]         rd_data;
  logic                     tbl_wr_en;
  logic [WIDTH-1:0]         tbl_wr_data;
  logic                     tbl_ready;
  lla_pkg::load_op_t        load_op;
  logic [CORE_BITS-1:0]     sel;
  logic                     sel_full;
  logic [CORE_BITS-1:0]     best;
  logic [REF_BITS-1:0]      refs;
  logic [REF_BITS-1:0]      ref_inc;
  logic [REF_BITS-1:0]      ref_dec;
  logic [CORE_BITS-1:0]     stored;
  logic                     ref_zero;
  lla_pkg::status_t         status_next;
  logic [CFB-1:0]           core_next;

  assign busy   = (state != S_IDLE) || !tbl_ready;
  assign accept = start && !busy;

  lla_index #(.TABLE_DEPTH(TABLE_DEPTH)) u_index (
    .clk         (clk),
    .capture     (accept),
    .file_number (file_number),
    .idx         (idx)
  );

  lla_table #(.TABLE_DEPTH(TABLE_DEPTH), .WIDTH(WIDTH)) u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (state == S_ADDR),
    .rd_addr (idx),
    .rd_data (rd_data),
    .wr_en   (tbl_wr_en),
    .wr_addr (idx),
    .wr_data (tbl_wr_data),
    .ready   (tbl_ready)
  );

  lla_load #(.CORE_COUNT(CORE_COUNT)) u_load (
    .clk      (clk),
    .rst      (rst),
    .op       (load_op),
    .sel      (sel),
    .sel_full (sel_full),
    .best     (best)
  );

  assign refs     = rd_data[REF_BITS-1:0];
  assign stored   = rd_data[REF_BITS +: CORE_BITS];
  assign ref_zero = refs == '0;
  assign ref_inc  = refs + REF_BITS'(1);
  assign ref_dec  = refs - REF_BITS'(1);
  assign sel      = (op_q == lla_pkg::OP_OPEN && ref_zero) ? best : stored;

  always_comb begin
    tbl_wr_en   = 1'b0;
    tbl_wr_data = rd_data;
    load_op     = '0;
    core_next   = '0;
    status_next = lla_pkg::ST_FULL;
    if (state == S_EXEC) begin
      if (op_q == lla_pkg::OP_OPEN) begin
        if (refs == '1 || sel_full) begin
          status_next = lla_pkg::ST_FULL;
        end else begin
          tbl_wr_en   = 1'b1;
          tbl_wr_data = {sel, ref_inc};
          load_op.inc = 1'b1;
          core_next   = CFB'(sel);
          status_next = lla_pkg::ST_OPENED;
        end
      end else if (ref_zero) begin
        status_next = lla_pkg::ST_REDUNDANT;
      end else begin
        tbl_wr_en   = 1'b1;
        tbl_wr_data = {(ref_dec == '0) ? CORE_BITS'(0) : stored, ref_dec};
        load_op.dec = 1'b1;
        status_next = lla_pkg::ST_CLOSED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_q  <= operation;
            state <= S_ADDR;
          end
        end
        S_ADDR: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          done   <= 1'b1;
          core   <= core_next;
          status <= status_next;
          state  <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_EXEC))
    else $error("result strobe without an executed word");

  a_no_write_while_clearing: assert property (@(posedge clk) disable iff (rst)
    !tbl_ready |-> !tbl_wr_en)
    else $error("table write during the clearing sweep");

  a_core_zero_unless_opened: assert property (@(posedge clk) disable iff (rst)
    (done && status != lla_pkg::ST_OPENED) |-> core == '0)
    else $error("core set on a result other than opened");

  a_load_op_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(load_op.inc && load_op.dec))
    else $error("core counter raised and lowered together");

  a_free_after_exec: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) |=> !busy)
    else $error("block still busy after executing a word");

endmodule
